FILE: sv/ts_packet_header_parse_top_macros.svh
// ============================================================================
// Assertion macros for the transport stream header parser
// Shorthand for clocked concurrent assertions that report through $error.
// ============================================================================
`ifndef TS_PACKET_HEADER_PARSE_TOP_MACROS_SVH
`define TS_PACKET_HEADER_PARSE_TOP_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define TSPHP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is checked during reset as well.
`define TSPHP_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/tsphp_pkg.sv
// ============================================================================
// Transport stream header parser package
// Constants and types shared by the parser and its checker.
// ============================================================================
package tsphp_pkg;

   localparam logic [7:0] SYNC_MARKER = 8'h47;

   // Header lengths: the fixed four-byte header, plus the length byte itself.
   localparam logic [8:0] HDR_LEN_BASE   = 9'd4;
   localparam logic [8:0] HDR_LEN_ADAPT  = 9'd5;

   // Index of the next header byte to be taken.
   localparam logic [3:0] POS_IDLE       = 4'd0;
   localparam logic [3:0] POS_HDR_FIRST  = 4'd1;
   localparam logic [3:0] POS_HDR_LAST   = 4'd3;
   localparam logic [3:0] POS_ADAPT_LEN  = 4'd4;
   localparam logic [3:0] POS_ADAPT_FLAG = 4'd5;
   localparam logic [3:0] POS_PCR_FIRST  = 4'd6;
   localparam logic [3:0] POS_PCR_LAST   = 4'd11;

   // Bit positions inside header and adaptation bytes.
   localparam int ADAPT_PRESENT_BIT = 5;
   localparam int PCR_FLAG_BIT      = 4;

   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_SYNC_ERR  = 1'b1;

   typedef struct packed {
      logic        status;
      logic [12:0] pid;
      logic [2:0]  header_flags;
      logic [1:0]  scrambling_control;
      logic [1:0]  adaptation_control;
      logic [3:0]  continuity_count;
      logic [7:0]  adaptation_length;
      logic [7:0]  adaptation_flags;
      logic        pcr_present;
      logic [32:0] clock_ref_base;
      logic [8:0]  clock_ref_ext;
      logic [8:0]  header_length;
   } rsp_word_type;

endpackage

FILE: sv/ts_packet_header_parse_top.sv
// ============================================================================
// Transport stream packet header parser
// Byte-wide parser for the four-byte header, adaptation field head and PCR.
// ============================================================================
// The block takes one transport stream byte per word on the req_ channel,
// with req_packet_start marking the first byte of each packet, and sustains
// one byte per clock cycle. A byte is captured in an input register, from
// which a single pass of byte-position logic updates the header state and,
// when a header completes, loads the result register; a result therefore
// appears on rsp_ from the result register once its last header byte has
// left the input register. A wrong sync byte at a packet start gives a
// result with rsp_status set and all other fields zero. Otherwise one
// result follows the last header byte: the fourth byte when no adaptation
// field is present, the length byte when that length is zero, the flag
// byte when the PCR flag is clear, and otherwise the sixth PCR byte. The
// PCR bytes are taken whatever the adaptation field length says, while
// rsp_header_length follows the length byte when an adaptation field is
// present. Bytes after a finished header are dropped until the next packet
// start, and a packet start in the middle of a header abandons that header
// without a result. Bytes that give no result keep flowing while a result
// waits on rsp_ready; only a byte that completes a header waits for the
// result register to free up.
// ============================================================================
module ts_packet_header_parse_top
   import tsphp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_packet_start,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_status,
   output logic [12:0] rsp_pid,
   output logic [2:0]  rsp_header_flags,
   output logic [1:0]  rsp_scrambling_control,
   output logic [1:0]  rsp_adaptation_control,
   output logic [3:0]  rsp_continuity_count,
   output logic [7:0]  rsp_adaptation_length,
   output logic [7:0]  rsp_adaptation_flags,
   output logic        rsp_pcr_present,
   output logic [32:0] rsp_clock_ref_base,
   output logic [8:0]  rsp_clock_ref_ext,
   output logic [8:0]  rsp_header_length
);

   // Input register.
   logic         byte_valid_ff;
   logic [7:0]   byte_data_ff;
   logic         byte_start_ff;

   // Parser state.
   logic [3:0]   pos_ff,        pos_in;
   logic         active_ff,     active_in;
   logic [23:0]  hdr_word_ff,   hdr_word_in;
   logic [7:0]   adapt_len_ff,  adapt_len_in;
   logic [7:0]   adapt_flag_ff, adapt_flag_in;
   logic [47:0]  pcr_shift_ff,  pcr_shift_in;

   // Result register.
   logic         rsp_valid_ff;
   rsp_word_type rsp_word_ff,   rsp_word_in;

   logic         emit_sync_err;
   logic         emit_hdr;
   logic         emit_pcr;
   logic         emit;
   logic         advance;
   logic         has_adapt;

   // The buffered byte moves on when it gives no result, or when the result
   // register is empty or being emptied in this cycle.
   assign emit      = emit_sync_err | emit_hdr;
   assign advance   = byte_valid_ff & (~emit | ~rsp_valid_ff | rsp_ready);
   assign req_ready = ~byte_valid_ff | advance;

   // Next state of the parser for the buffered byte.
   always_comb begin
      pos_in        = pos_ff;
      active_in     = active_ff;
      hdr_word_in   = hdr_word_ff;
      adapt_len_in  = adapt_len_ff;
      adapt_flag_in = adapt_flag_ff;
      pcr_shift_in  = pcr_shift_ff;
      emit_sync_err = 1'b0;
      emit_hdr      = 1'b0;
      emit_pcr      = 1'b0;

      if (byte_start_ff) begin
         pos_in        = POS_IDLE;
         active_in     = 1'b0;
         hdr_word_in   = '0;
         adapt_len_in  = '0;
         adapt_flag_in = '0;
         pcr_shift_in  = '0;
         if (byte_data_ff == SYNC_MARKER) begin
            active_in = 1'b1;
            pos_in    = POS_HDR_FIRST;
         end else begin
            emit_sync_err = byte_valid_ff;
         end
      end else if (active_ff) begin
         if (pos_ff >= POS_HDR_FIRST && pos_ff <= POS_HDR_LAST) begin
            hdr_word_in = {hdr_word_ff[15:0], byte_data_ff};
            if (pos_ff != POS_HDR_LAST) begin
               pos_in = pos_ff + 4'd1;
            end else if (!byte_data_ff[ADAPT_PRESENT_BIT]) begin
               emit_hdr = byte_valid_ff;
            end else begin
               pos_in = POS_ADAPT_LEN;
            end
         end else if (pos_ff == POS_ADAPT_LEN) begin
            adapt_len_in = byte_data_ff;
            if (byte_data_ff == 8'd0) begin
               emit_hdr = byte_valid_ff;
            end else begin
               pos_in = POS_ADAPT_FLAG;
            end
         end else if (pos_ff == POS_ADAPT_FLAG) begin
            adapt_flag_in = byte_data_ff;
            if (!byte_data_ff[PCR_FLAG_BIT]) begin
               emit_hdr = byte_valid_ff;
            end else begin
               pos_in = POS_PCR_FIRST;
            end
         end else if (pos_ff >= POS_PCR_FIRST && pos_ff <= POS_PCR_LAST) begin
            pcr_shift_in = {pcr_shift_ff[39:0], byte_data_ff};
            if (pos_ff == POS_PCR_LAST) begin
               emit_hdr = byte_valid_ff;
               emit_pcr = 1'b1;
            end else begin
               pos_in = pos_ff + 4'd1;
            end
         end else begin
            pos_in    = POS_IDLE;
            active_in = 1'b0;
         end
      end

      // A finished header sends the parser back to idle.
      if (emit_hdr) begin
         pos_in    = POS_IDLE;
         active_in = 1'b0;
      end
   end

   // Result fields, taken from the updated header state.
   assign has_adapt = hdr_word_in[ADAPT_PRESENT_BIT];

   always_comb begin
      rsp_word_in = '0;
      if (emit_sync_err) begin
         rsp_word_in.status = STATUS_SYNC_ERR;
      end else begin
         rsp_word_in.status             = STATUS_OK;
         rsp_word_in.pid                = {hdr_word_in[20:16], hdr_word_in[15:8]};
         rsp_word_in.header_flags       = hdr_word_in[23:21];
         rsp_word_in.scrambling_control = hdr_word_in[7:6];
         rsp_word_in.adaptation_control = hdr_word_in[5:4];
         rsp_word_in.continuity_count   = hdr_word_in[3:0];
         rsp_word_in.pcr_present        = emit_pcr;
         if (emit_pcr) begin
            rsp_word_in.clock_ref_base = pcr_shift_in[47:15];
            rsp_word_in.clock_ref_ext  = pcr_shift_in[8:0];
         end
         if (has_adapt) begin
            rsp_word_in.adaptation_length = adapt_len_in;
            rsp_word_in.header_length     = HDR_LEN_ADAPT + {1'b0, adapt_len_in};
            if (adapt_len_in != 8'd0) begin
               rsp_word_in.adaptation_flags = adapt_flag_in;
            end
         end else begin
            rsp_word_in.header_length = HDR_LEN_BASE;
         end
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_valid_ff <= 1'b0;
      end else if (req_ready) begin
         byte_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_data_ff  <= req_data_byte;
         byte_start_ff <= req_packet_start;
      end
   end

   // Parser state.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= POS_IDLE;
         active_ff <= 1'b0;
      end else if (advance) begin
         pos_ff    <= pos_in;
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         hdr_word_ff   <= hdr_word_in;
         adapt_len_ff  <= adapt_len_in;
         adapt_flag_ff <= adapt_flag_in;
         pcr_shift_ff  <= pcr_shift_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = rsp_word_ff.status;
   assign rsp_pid                = rsp_word_ff.pid;
   assign rsp_header_flags       = rsp_word_ff.header_flags;
   assign rsp_scrambling_control = rsp_word_ff.scrambling_control;
   assign rsp_adaptation_control = rsp_word_ff.adaptation_control;
   assign rsp_continuity_count   = rsp_word_ff.continuity_count;
   assign rsp_adaptation_length  = rsp_word_ff.adaptation_length;
   assign rsp_adaptation_flags   = rsp_word_ff.adaptation_flags;
   assign rsp_pcr_present        = rsp_word_ff.pcr_present;
   assign rsp_clock_ref_base     = rsp_word_ff.clock_ref_base;
   assign rsp_clock_ref_ext      = rsp_word_ff.clock_ref_ext;
   assign rsp_header_length      = rsp_word_ff.header_length;

endmodule

FILE: sv/tsphp_checker.sv
// ============================================================================
// Transport stream header parser checker
// Port-level checks on the result words, bound to the top level.
// ============================================================================
`include "ts_packet_header_parse_top_macros.svh"

module tsphp_checker
   import tsphp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_status,
   input logic [12:0] rsp_pid,
   input logic [1:0]  rsp_adaptation_control,
   input logic [7:0]  rsp_adaptation_length,
   input logic        rsp_pcr_present,
   input logic [32:0] rsp_clock_ref_base,
   input logic [8:0]  rsp_clock_ref_ext,
   input logic [8:0]  rsp_header_length
);

   // A result word that is not taken stays valid on the port.
   `TSPHP_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid,
      "result word dropped before it was taken")

   // No result word right after reset.
   `TSPHP_ASSERT_ALWAYS(a_rsp_reset, clock, $past(reset) |-> !rsp_valid,
      "result word valid after reset")

   // A sync error carries no header contents.
   `TSPHP_ASSERT(a_sync_err_empty, clock, reset,
      rsp_valid && rsp_status == STATUS_SYNC_ERR |->
         rsp_header_length == 9'd0 && rsp_pid == 13'd0 && !rsp_pcr_present,
      "sync error word carries header fields")

   // The header length follows the adaptation field control and length byte.
   `TSPHP_ASSERT(a_hdr_len, clock, reset,
      rsp_valid && rsp_status == STATUS_OK |->
         (rsp_adaptation_control[1] ?
             rsp_header_length == HDR_LEN_ADAPT + {1'b0, rsp_adaptation_length} :
             rsp_header_length == HDR_LEN_BASE && rsp_adaptation_length == 8'd0),
      "header length does not match the adaptation field")

   // PCR fields are zero unless a PCR was taken.
   `TSPHP_ASSERT(a_pcr_zero, clock, reset,
      rsp_valid && !rsp_pcr_present |->
         rsp_clock_ref_base == 33'd0 && rsp_clock_ref_ext == 9'd0,
      "PCR fields set without a PCR")

endmodule

bind ts_packet_header_parse_top tsphp_checker u_tsphp_checker (.*);
